### design/pixel_hit_packet_decoder_top_assert.svh
// Assertion macros for the pixel hit packet decoder.
// Both sample on clk and stay disabled while rst_n is low.
`ifndef PIXEL_HIT_PACKET_DECODER_TOP_ASSERT_SVH
`define PIXEL_HIT_PACKET_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PHPD_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PHPD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/phpd_pkg.sv
package phpd_pkg;

  typedef enum logic [1:0] {
    KIND_HIT     = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_TIMING  = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  localparam logic [3:0] HDR_HIT_A    = 4'hA;
  localparam logic [3:0] HDR_HIT_B    = 4'hB;
  localparam logic [3:0] HDR_TRIG_ALT = 4'h6;
  localparam logic [3:0] HDR_TIMING   = 4'h4;
  localparam logic [3:0] SUB_TRIGGER  = 4'hF;

  localparam logic CFG_COLUMN_OFFSET   = 1'b0;
  localparam logic CFG_USE_LOCAL_TIMER = 1'b1;

  localparam int FINE_W   = 42;
  localparam int COARSE_W = 18;

  typedef struct packed {
    kind_t                kind;
    logic                 is_hit;
    logic                 advance;
    logic [15:0]          addr;
    logic [7:0]           col;
    logic [7:0]           row;
    logic [9:0]           tot;
    logic [FINE_W-1:0]    fine;
    logic [COARSE_W-1:0]  coarse;
  } decode_t;

endpackage

### design/pixel_hit_packet_decoder_top.sv
// Pipeline: a packet passes the input register, then the result register, before
//   out_valid rises for it.
// Throughput: 1 packet per cycle while out_ready stays high; the local timer is updated
//   as a hit leaves the input stage, so back-to-back hits see each other's timer step.
// Reset: synchronous active-low rst_n clears both valid flags, the local timer and
//   the configuration registers; payload registers are not reset.
`include "pixel_hit_packet_decoder_top_assert.svh"

module pixel_hit_packet_decoder_top
  import phpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_packet,
  input  logic [63:0] in_ext_time,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_packet_kind,
  output logic [15:0] out_pixel_address,
  output logic [7:0]  out_pixel_column,
  output logic [7:0]  out_pixel_row,
  output logic [10:0] out_sensor_column,
  output logic [9:0]  out_over_threshold_time,
  output logic [59:0] out_hit_time
);

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  logic [9:0]  column_offset_r;
  logic        use_local_timer_r;

  // Input stage.
  logic        s1_valid_r;
  logic [63:0] s1_packet_r;
  logic [63:0] s1_gtime_r;

  // Reference timer carried across hits.
  logic [63:0] local_timer_r;
  logic [63:0] local_timer_nxt;

  // Result stage.
  logic        out_valid_r;
  kind_t       kind_r;
  logic [15:0] addr_r;
  logic [7:0]  col_r;
  logic [7:0]  row_r;
  logic [10:0] scol_r;
  logic [9:0]  tot_r;
  logic [59:0] htime_r;

  decode_t     dec;
  logic        s1_adv;

  // Advance the input stage whenever the result register is free or being drained.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_offset_r   <= '0;
      use_local_timer_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLUMN_OFFSET:   column_offset_r   <= cfg_wdata;
        CFG_USE_LOCAL_TIMER: use_local_timer_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_packet_r <= in_packet;
      s1_gtime_r  <= in_ext_time;
    end
  end

  phpd_decode u_decode (
    .packet          (s1_packet_r),
    .ext_time        (s1_gtime_r),
    .use_local_timer (use_local_timer_r),
    .local_timer     (local_timer_r),
    .dec             (dec)
  );

  // Step the local timer one window when a hit leaving the input stage runs ahead of it.
  always_comb begin
    local_timer_nxt = local_timer_r;
    if (s1_adv && dec.advance) begin
      local_timer_nxt = {local_timer_r[63:40] + 24'd1, local_timer_r[39:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_timer_r <= '0;
    end else begin
      local_timer_r <= local_timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Drop every hit field to zero for non-hit packets.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      kind_r <= dec.kind;
      if (dec.is_hit) begin
        addr_r  <= dec.addr;
        col_r   <= dec.col;
        row_r   <= dec.row;
        scol_r  <= {3'd0, dec.col} + {1'b0, column_offset_r};
        tot_r   <= dec.tot;
        htime_r <= {dec.coarse, dec.fine};
      end else begin
        addr_r  <= '0;
        col_r   <= '0;
        row_r   <= '0;
        scol_r  <= '0;
        tot_r   <= '0;
        htime_r <= '0;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_packet_kind         = kind_r;
  assign out_pixel_address       = addr_r;
  assign out_pixel_column        = col_r;
  assign out_pixel_row           = row_r;
  assign out_sensor_column       = scol_r;
  assign out_over_threshold_time = tot_r;
  assign out_hit_time            = htime_r;

  `PHPD_CHECK_NOW(a_nonhit_zero, out_valid_r && (kind_r != KIND_HIT),
                  (htime_r == '0) && (scol_r == '0), "non-hit result carries hit fields")
  `PHPD_CHECK_NEXT(a_timer_hold, !(s1_adv && dec.is_hit), $stable(local_timer_r),
                   "local timer moved without a hit transfer")
  `PHPD_CHECK_NOW(a_sensor_col, out_valid_r && (kind_r == KIND_HIT),
                  scol_r == ({3'd0, col_r} + {1'b0, column_offset_r}), "sensor column mismatch")

endmodule

### design/phpd_decode.sv
module phpd_decode
  import phpd_pkg::*;
(
  input  logic [63:0] packet,
  input  logic [63:0] ext_time,
  input  logic        use_local_timer,
  input  logic [63:0] local_timer,
  output decode_t     dec
);

  logic [3:0]  header;
  logic [3:0]  sub;
  logic [63:0] ref_time;
  logic [1:0]  win_diff;
  logic [19:0] ref_hi;
  logic [19:0] ref_adj;

  assign header   = packet[63:60];
  assign sub      = packet[59:56];
  assign ref_time = use_local_timer ? local_timer : ext_time;

  always_comb begin
    dec.addr = packet[59:44];
    dec.col  = {dec.addr[15:9], dec.addr[2]};
    dec.row  = {dec.addr[8:3], dec.addr[1:0]};
    dec.tot  = packet[29:20];
    dec.fine = {packet[15:0], packet[43:30], ~packet[19:16], 8'd0};

    // pull the reference one window toward the hit time
    ref_hi   = ref_time[59:40];
    win_diff = ref_time[41:40] - dec.fine[41:40];
    case (win_diff)
      2'd1:    ref_adj = ref_hi - 20'd1;
      2'd3:    ref_adj = ref_hi + 20'd1;
      default: ref_adj = ref_hi;
    endcase
    dec.coarse = ref_adj[19:2];

    case (header)
      HDR_HIT_A, HDR_HIT_B: dec.kind = KIND_HIT;
      HDR_TRIG_ALT:         dec.kind = (sub == SUB_TRIGGER) ? KIND_TRIGGER : KIND_UNKNOWN;
      HDR_TIMING: begin
        if (sub == SUB_TRIGGER) dec.kind = KIND_TRIGGER;
        else if (!use_local_timer) dec.kind = KIND_TIMING;
        else dec.kind = KIND_UNKNOWN;
      end
      default:              dec.kind = KIND_UNKNOWN;
    endcase
    dec.is_hit  = (dec.kind == KIND_HIT);
    dec.advance = dec.is_hit && (dec.fine[41:40] == (local_timer[41:40] + 2'd1));
  end

endmodule
